@@ rtl/sbp_pkg.sv @@
// Shared types and constants for the seven-bit pack codec.
`timescale 1ns / 1ps

package sbp_pkg;

    // Bytes per group: seven data bytes share one overflow byte
    localparam int GROUP_LEN = 7;
    localparam int POS_W     = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Result handed from the codec core to the output register
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } out_load_t;

endpackage

@@ rtl/sbp_out_stage.sv @@
// Output register stage: holds one result item until the sink takes it.
`timescale 1ns / 1ps

module sbp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  sbp_pkg::out_load_t load,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output sbp_pkg::out_item_t out_data
);
    import sbp_pkg::*;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Register is free when empty or being drained this cycle
    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            out_data_reg <= load.item;
        end
    end

endmodule

@@ rtl/sbp_core.sv @@
// Codec core: group state, decode frame store and result burst sequencing.
`timescale 1ns / 1ps

module sbp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sbp_pkg::in_item_t  in_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               can_load,
    output sbp_pkg::out_load_t load
);
    import sbp_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(GROUP_LEN - 1);
    localparam logic [POS_W-1:0] FULL_POS = POS_W'(GROUP_LEN);

    // Control state
    logic             decode_mode_reg, decode_mode_next;
    logic [6:0]       acc_reg, acc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             burst_active_reg, burst_active_next;
    logic             burst_enc_reg, burst_enc_next;
    logic [POS_W-1:0] burst_idx_reg, burst_idx_next;
    logic [POS_W-1:0] burst_cnt_reg, burst_cnt_next;
    logic             burst_last_reg, burst_last_next;
    // Payload state
    logic [7:0]       burst_ovf_reg, burst_ovf_next;
    logic [6:0]       frame_store_reg [GROUP_LEN];

    logic             store_we;
    logic [POS_W-1:0] store_idx;
    logic [6:0]       store_data;

    logic             accept;
    logic             dec_is_ovf;
    logic             buffer_ok;
    logic [POS_W-1:0] enc_pos;
    logic [6:0]       enc_acc_base;
    logic [6:0]       enc_acc_new;
    logic [6:0]       ovf_shift;
    logic [6:0]       rd_entry;

    assign cfg_ready = 1'b1;

    // Input acceptance: while a decode burst drains, only buffering bytes
    // that land in already emitted entries are taken
    always_comb
    begin
        dec_is_ovf = (pos_reg >= FULL_POS) || in_data.last_in;
        buffer_ok  = decode_mode_reg && !dec_is_ovf;
        if (burst_active_reg)
        begin
            in_ready = buffer_ok && !burst_enc_reg && (pos_reg < burst_idx_reg);
        end
        else
        begin
            in_ready = can_load || buffer_ok;
        end
        accept = in_valid && in_ready;
    end

    // Encode overflow bit gathering
    always_comb
    begin
        enc_pos      = (pos_reg >= FULL_POS) ? '0 : pos_reg;
        enc_acc_base = (pos_reg >= FULL_POS) ? '0 : acc_reg;
        enc_acc_new  = enc_acc_base | ({in_data.data_byte[7], 6'b0} >> enc_pos);
    end

    // Burst read of the frame store
    always_comb
    begin
        rd_entry  = frame_store_reg[burst_idx_reg];
        ovf_shift = burst_ovf_reg[6:0] << burst_idx_reg;
    end

    // Next state and result selection
    always_comb
    begin
        decode_mode_next  = decode_mode_reg;
        acc_next          = acc_reg;
        pos_next          = pos_reg;
        burst_active_next = burst_active_reg;
        burst_enc_next    = burst_enc_reg;
        burst_idx_next    = burst_idx_reg;
        burst_cnt_next    = burst_cnt_reg;
        burst_last_next   = burst_last_reg;
        burst_ovf_next    = burst_ovf_reg;
        load              = '0;
        store_we          = 1'b0;
        store_idx         = pos_reg;
        store_data        = in_data.data_byte[6:0];

        // Drain one pending result item
        if (burst_active_reg && can_load)
        begin
            load.valid = 1'b1;
            if (burst_enc_reg)
            begin
                load.item.out_byte = burst_ovf_reg;
                load.item.out_last = burst_last_reg;
                burst_active_next  = 1'b0;
            end
            else
            begin
                load.item.out_byte = {ovf_shift[6], rd_entry};
                load.item.out_last = burst_last_reg &&
                                     (burst_idx_reg == burst_cnt_reg - 1'b1);
                if (burst_idx_reg == burst_cnt_reg - 1'b1)
                begin
                    burst_active_next = 1'b0;
                end
                else
                begin
                    burst_idx_next = burst_idx_reg + 1'b1;
                end
            end
        end

        // New input item
        if (accept)
        begin
            if (!decode_mode_reg)
            begin
                load.valid         = 1'b1;
                load.item.out_byte = {1'b0, in_data.data_byte[6:0]};
                load.item.out_last = 1'b0;
                if ((enc_pos == LAST_POS) || in_data.last_in)
                begin
                    burst_active_next = 1'b1;
                    burst_enc_next    = 1'b1;
                    burst_ovf_next    = {1'b0, enc_acc_new};
                    burst_last_next   = in_data.last_in;
                    acc_next          = '0;
                    pos_next          = '0;
                end
                else
                begin
                    acc_next = enc_acc_new;
                    pos_next = enc_pos + 1'b1;
                end
            end
            else if (!dec_is_ovf)
            begin
                store_we = 1'b1;
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                acc_next = '0;
                pos_next = '0;
                if (pos_reg != '0)
                begin
                    load.valid         = 1'b1;
                    load.item.out_byte = {in_data.data_byte[6], frame_store_reg[0]};
                    load.item.out_last = in_data.last_in && (pos_reg == POS_W'(1));
                    if (pos_reg != POS_W'(1))
                    begin
                        burst_active_next = 1'b1;
                        burst_enc_next    = 1'b0;
                        burst_idx_next    = POS_W'(1);
                        burst_cnt_next    = pos_reg;
                        burst_ovf_next    = in_data.data_byte;
                        burst_last_next   = in_data.last_in;
                    end
                end
            end
        end

        // Mode write restarts the group
        if (cfg_valid)
        begin
            decode_mode_next = cfg_data;
            acc_next         = '0;
            pos_next         = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg  <= 1'b0;
            acc_reg          <= '0;
            pos_reg          <= '0;
            burst_active_reg <= 1'b0;
            burst_enc_reg    <= 1'b0;
            burst_idx_reg    <= '0;
            burst_cnt_reg    <= '0;
            burst_last_reg   <= 1'b0;
        end
        else
        begin
            decode_mode_reg  <= decode_mode_next;
            acc_reg          <= acc_next;
            pos_reg          <= pos_next;
            burst_active_reg <= burst_active_next;
            burst_enc_reg    <= burst_enc_next;
            burst_idx_reg    <= burst_idx_next;
            burst_cnt_reg    <= burst_cnt_next;
            burst_last_reg   <= burst_last_next;
        end
    end

    // Payload registers and frame store, no reset
    always_ff @(posedge clk)
    begin
        burst_ovf_reg <= burst_ovf_next;
        if (store_we)
        begin
            frame_store_reg[store_idx] <= store_data;
        end
    end

    // A byte buffered during a burst must not overwrite an unread entry;
    // the write position may catch up with the read index but never pass it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active_reg && !burst_enc_reg |-> pos_reg <= burst_idx_reg)
        else $error("new group overran a draining frame");

    // Burst index stays inside the buffered count
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active_reg && !burst_enc_reg |-> burst_idx_reg < burst_cnt_reg)
        else $error("burst index out of range");

    // Nothing is taken while an encode overflow byte waits
    a_enc_block: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active_reg && burst_enc_reg |-> !in_ready && pos_reg == '0)
        else $error("input taken during encode overflow");

    // Items accepted during a burst never produce a result
    a_burst_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active_reg && accept |-> decode_mode_reg && !in_data.last_in)
        else $error("result-producing item taken during a burst");

endmodule

@@ rtl/seven_bit_pack_codec.sv @@
// Top level of the seven-bit pack codec: 8-to-7 bit packing and unpacking.
// The first result item of an input item is in the output register in the cycle after accept.
// Encode: one item per cycle unless stalled; a group end adds its overflow byte, blocking input.
// Decode: one item per cycle when buffering to a free entry; overflow bytes wait out a prior burst.
// A decode burst emits one restored byte per cycle unless stalled, from the 7-entry frame store.
// Reset: encode mode, empty group, no result pending; frame store contents are not reset.
`timescale 1ns / 1ps

module seven_bit_pack_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sbp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sbp_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import sbp_pkg::*;

    out_load_t load;
    logic      can_load;

    // Group state and burst sequencing
    sbp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .can_load  (can_load),
        .load      (load)
    );

    // Result register
    sbp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ verif/tb.sv @@
// Testbench for the seven-bit pack codec: directed and random byte streams checked by a group predictor.
`timescale 1ns / 1ps

module tb;
    import sbp_pkg::*;

    localparam bit MODE_ENCODE   = 1'b0;
    localparam bit MODE_DECODE   = 1'b1;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 56;
    localparam int NUM_PHASES    = 8;

    // Predicts result bytes per accepted item and checks them in order
    class group_board;
        bit        decode_mode;
        bit [6:0]  top_bits;
        int        fill;
        bit [6:0]  frame [GROUP_LEN];
        out_item_t expected_bytes [$];
        int        errors;

        function new();
            errors = 0;
            set_mode(MODE_ENCODE);
        endfunction

        // Any mode write drops a partly built group
        function void set_mode(bit m);
            decode_mode = m;
            top_bits    = '0;
            fill        = 0;
        endfunction

        function void push_byte(logic [7:0] b, logic l);
            out_item_t r;
            r.out_byte = b;
            r.out_last = l;
            expected_bytes.push_back(r);
        endfunction

        function void take_input(in_item_t it);
            int k;
            if (decode_mode == MODE_ENCODE)
            begin
                // top bit goes into the overflow byte, bit 6 first
                top_bits[6 - fill] = it.data_byte[7];
                push_byte({1'b0, it.data_byte[6:0]}, 1'b0);
                fill++;
                if (fill == GROUP_LEN || it.last_in)
                begin
                    push_byte({1'b0, top_bits}, it.last_in);
                    top_bits = '0;
                    fill     = 0;
                end
            end
            else if (fill < GROUP_LEN && !it.last_in)
            begin
                // buffered data byte keeps only its low 7 bits
                frame[fill] = it.data_byte[6:0];
                fill++;
            end
            else
            begin
                // overflow byte: restore bit 7 of each buffered byte
                for (k = 0; k < fill; k++)
                    push_byte({it.data_byte[6 - k], frame[k]},
                              (k == fill - 1) ? it.last_in : 1'b0);
                fill = 0;
            end
        endfunction

        function void check_output(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item: expected none, actual byte %02h last %0b",
                         $time, got.out_byte, got.out_last);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                errors++;
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, want.out_byte, got.out_byte);
            end
            if (got.out_last !== want.out_last)
            begin
                errors++;
                $display("%0t: out_last mismatch: expected %0b, actual %0b",
                         $time, want.out_last, got.out_last);
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    bit         calm       = 1'b0;
    int         items_sent = 0;
    group_board board;

    seven_bit_pack_codec u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver stalls about 8 percent of the time, never during a calm stretch
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 8);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_output(out_data);
    end

    // Send one item, with an occasional idle gap ahead of it
    task automatic send_item(logic [7:0] b, logic l);
        in_item_t it;
        it.data_byte = b;
        it.last_in   = l;
        if (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        board.take_input(it);
        items_sent++;
    endtask

    // Hold the sender until every expected item has come, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(bit m);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        board.set_mode(m);
        cfg_valid <= 1'b0;
    endtask

    // Raw message for the packer: last marker on the final byte
    task automatic send_raw_message(int len);
        int i;
        for (i = 0; i < len; i++)
            send_item(8'($urandom_range(255)), i == len - 1);
    endtask

    // Packed message for the unpacker: groups of up to 7 data bytes, each closed by
    // an overflow byte; the final one carries the last marker
    task automatic send_packed_message(int len);
        int left;
        int n;
        int i;
        left = len;
        while (left > 0)
        begin
            n = (left > GROUP_LEN) ? GROUP_LEN : left;
            for (i = 0; i < n; i++)
                send_item(8'($urandom_range(255)), 1'b0);
            left -= n;
            send_item(8'($urandom_range(255)), left == 0);
        end
    endtask

    initial
    begin
        int  phase;
        int  start;
        int  pick;
        bit  mode;
        bit  paused;
        board  = new();
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Packer: extremes, a full group, a one-byte message, then a group cut by a mode write
        write_mode(MODE_ENCODE);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hFE, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b1);
        send_item(8'hC3, 1'b0);
        send_item(8'h81, 1'b0);

        // Unpacker: full group with bit 7 set on data and overflow, lone overflow byte,
        // short message, then a partial group dropped by a mode write
        write_mode(MODE_DECODE);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h2A, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h7F, 1'b1);
        send_item(8'h12, 1'b0);
        send_item(8'hF3, 1'b0);
        send_item(8'hC0, 1'b1);
        send_item(8'h5A, 1'b0);
        write_mode(MODE_DECODE);

        // Random phases, alternating modes
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            mode = phase[0];
            write_mode(mode);
            calm  = (phase == 3);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if (phase == 2 && !paused && items_sent - start >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                pick = $urandom_range(9);
                if (pick < 8)
                begin
                    if (mode == MODE_DECODE)
                        send_packed_message($urandom_range(20, 1));
                    else
                        send_raw_message($urandom_range(20, 1));
                end
                else if (pick == 8)
                begin
                    // noise: random bytes and markers
                    repeat ($urandom_range(4, 1))
                        send_item(8'($urandom_range(255)), $urandom_range(3) == 0);
                end
                else
                begin
                    // marked byte; in decode mode, a lone overflow byte when the group is empty
                    send_item(8'($urandom_range(255)), 1'b1);
                end
            end
        end
        calm = 1'b0;
        drain();

        if (board.errors == 0 && board.expected_bytes.size() == 0)
            $display("seven_bit_pack_codec test passed");
        else
            $display("seven_bit_pack_codec test failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("seven_bit_pack_codec test failed");
        $finish;
    end

endmodule
